// ===== rtl/switch_matrix_vertical_debounce_top_defines.svh =====
// Assertion macros for the switch matrix debounce RTL.
`ifndef SWITCH_MATRIX_VERTICAL_DEBOUNCE_TOP_DEFINES_SVH
`define SWITCH_MATRIX_VERTICAL_DEBOUNCE_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define SMVD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define SMVD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/smvd_pkg.sv =====
// Package: constants, row entry type, state enum and a helper for the debounce block.
`timescale 1ns / 1ps
package smvd_pkg;
	localparam int ROW_COUNT = 8;
	localparam int COLS      = 8;
	localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int COL_W     = 3;
	localparam int ID_W      = 6;
	localparam int ENTRY_W   = 3 * COLS;
	localparam logic [7:0] MASK_RESET = 8'hFF;

	typedef logic [COLS-1:0] cols_t;

	typedef struct packed {
		cols_t deb;
		cols_t hi;
		cols_t lo;
	} row_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_EMIT
	} state_t;

	// index of the lowest set bit (0 when none)
	function automatic logic [COL_W-1:0] lowest_col(cols_t v);
		logic [COL_W-1:0] idx;
		idx = '0;
		for (int i = COLS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = COL_W'(i);
			end
		end
		return idx;
	endfunction
endpackage

// ===== rtl/switch_matrix_vertical_debounce_top.sv =====
// Top level: 8x8 switch matrix scanner with per-row vertical-counter debounce.
// Flow: a sample is taken in IDLE, its row entry is read the next cycle in RD,
//   then the n flipped columns (n = 0..8) are registered as reports in EMIT,
//   one report per cycle unless m_tready stalls the output register; a new
//   sample is taken only after the row-store read/modify/write and reports.
// Reset (arst_n low): row 0, column mask 0xFF, all row entries read as zero
//   through per-row valid flops; no clearing pass is needed.
`timescale 1ns / 1ps
`include "switch_matrix_vertical_debounce_top_defines.svh"
module switch_matrix_vertical_debounce_top
	import smvd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// column sample stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] column_sample
	// switch change reports
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [5:0] switch_id, [6] now_closed, [7] zero
	output logic       m_tlast,   // last_of_run
	// column mask write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data   // [7:0] column_mask
);
	state_t state_q, state_d;

	logic [7:0]       mask_q;
	logic [ROW_W-1:0] row_q;      // strobe row of the next sample
	logic [ROW_W-1:0] rep_row_q;  // row of the reports in flight
	logic [ROW_COUNT-1:0] valid_q; // row entry written since reset

	cols_t sample_s1;
	logic  valid_s1;

	cols_t flip_q;  // columns still to report
	cols_t deb_q;   // updated debounced row

	logic             m_tvalid_q;
	logic [ID_W-1:0]  id_q;
	logic             closed_q;
	logic             last_q;

	// RAM side
	logic             ram_rd_en;
	logic             ram_we;
	logic [ENTRY_W-1:0] ram_rd_data;
	row_entry_t       cur, upd;

	// counter update
	cols_t delta, flip_c;

	// report selection
	logic             emit;
	cols_t            lo_onehot;
	logic [COL_W-1:0] col_sel;
	cols_t            flip_rest;

	assign cfg_ready = 1'b1;

	// one entry per row: debounced level plus the two counter bit-planes
	smvd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ROW_COUNT)
	) u_row_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (rep_row_q),
		.wr_data (upd),
		.rd_en   (ram_rd_en),
		.rd_addr (row_q),
		.rd_data (ram_rd_data)
	);

	// entry not yet written reads as the reset value
	always_comb begin
		cur = valid_s1 ? row_entry_t'(ram_rd_data) : '0;
		delta   = sample_s1 ^ cur.deb;
		upd.hi  = (cur.hi ^ cur.lo) & delta;
		upd.lo  = ~cur.lo & delta;
		flip_c  = delta & ~(upd.lo | upd.hi);
		upd.deb = cur.deb ^ flip_c;
	end

	// lowest pending column goes out first
	always_comb begin
		lo_onehot = flip_q & (~flip_q + cols_t'(1));
		col_sel   = lowest_col(flip_q);
		flip_rest = flip_q & ~lo_onehot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_rd_en = 1'b0;
		ram_we    = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ram_rd_en = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				ram_we  = 1'b1;
				state_d = (flip_c != '0) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					emit = 1'b1;
					if (flip_rest == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= MASK_RESET;
			row_q      <= '0;
			rep_row_q  <= '0;
			valid_q    <= '0;
			valid_s1   <= 1'b0;
			flip_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (s_tvalid && s_tready) begin
				valid_s1  <= valid_q[row_q];
				rep_row_q <= row_q;
			end
			if (state_q == ST_RD) begin
				valid_q[rep_row_q] <= 1'b1;
				flip_q <= flip_c;
				row_q  <= (row_q == ROW_W'(ROW_COUNT - 1)) ? '0 : row_q + ROW_W'(1);
			end else if (emit) begin
				flip_q <= flip_rest;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata & mask_q;
		end
		if (state_q == ST_RD) begin
			deb_q <= upd.deb;
		end
		if (emit) begin
			id_q     <= {3'(rep_row_q), col_sel};
			closed_q <= deb_q[col_sel];
			last_q   <= (flip_rest == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, closed_q, id_q};
	assign m_tlast  = last_q;

	`SMVD_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready, state_q == ST_RD, "accept not followed by row read")
	`SMVD_ASSERT_NOW(a_emit_pending, state_q == ST_EMIT, flip_q != '0, "report state with nothing pending")
	`SMVD_ASSERT_NOW(a_row_range, 1'b1, row_q <= ROW_W'(ROW_COUNT - 1), "scan row out of range")
endmodule

// ===== rtl/smvd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module smvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
